FILE: src/assert_macros.svh
// Assertion macros shared by the tone burst RTL.
// Depends on nothing; bodies collapse to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
// cons must follow whenever ante holds
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: src/dtb_pkg.sv
// Shared types, constants and the sine table of the tone burst block.
// Used by every module of the block; depends on nothing.
package dtb_pkg;

   localparam int SINE_ADDR_BITS = 8;
   localparam int COUNT_BITS     = 16;
   localparam int ROM_SIZE       = 1 << SINE_ADDR_BITS;
   localparam int QUARTER        = ROM_SIZE >> 2;
   localparam int REG_W          = 16;
   localparam int CMP_W          = ((COUNT_BITS > REG_W) ? COUNT_BITS : REG_W) + 1;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CQ_DEPTH       = 2;
   localparam int CQ_PTR_BITS    = $clog2(CQ_DEPTH);
   localparam int CQ_CNT_BITS    = $clog2(CQ_DEPTH + 1);

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   localparam logic [15:0]        CHAN_A_BITS = 16'h3000;
   localparam logic signed [11:0] DAC_SCALE   = 12'sd2047;
   localparam logic signed [15:0] DAC_OFFSET  = 16'sd2048;
   localparam logic signed [15:0] DAC_MAX     = 16'sd4095;

   localparam logic [CSR_INDEX_BITS-1:0] REG_ATTACK_STEP  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DECAY_STEP   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ATTACK_TICKS = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DECAY_TICKS  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BURST_LENGTH = 3'd4;

   localparam logic [REG_W-1:0] RST_ATTACK_STEP  = 16'd131;
   localparam logic [REG_W-1:0] RST_DECAY_STEP   = 16'd131;
   localparam logic [REG_W-1:0] RST_ATTACK_TICKS = 16'd250;
   localparam logic [REG_W-1:0] RST_DECAY_TICKS  = 16'd250;
   localparam logic [REG_W-1:0] RST_BURST_LENGTH = 16'd6500;

   localparam logic [1:0] VOICE_SWOOP = 2'd1;
   localparam logic [1:0] VOICE_CHIRP = 2'd2;

   // one sample command from the front to the back
   typedef struct packed {
      logic [SINE_ADDR_BITS-1:0] addr;
      logic [15:0]               amp;
      logic                      voiced;
      logic [15:0]               next_index;
      logic                      done;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } cq_status_type;

   typedef logic signed [15:0] sine_rom_type [ROM_SIZE];

   // round(32767 * sin(k * pi / (2 * QUARTER))) by a Taylor series in Q30
   function automatic logic signed [15:0] quarter_sine(input int unsigned k);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned v;
      longint          sum;
      begin
         x    = (64'(k) * HALF_PI_Q30) >> (SINE_ADDR_BITS - 2);
         x2   = (x * x) >> 30;
         term = x;
         sum  = longint'(x);
         for (int unsigned n = 1; n <= 9; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n[0]) sum = sum - longint'(term);
            else      sum = sum + longint'(term);
         end
         if (sum < 0) sum = 0;
         v = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
         if (v > 64'd32767) v = 64'd32767;
         return 16'(v);
      end
   endfunction

   function automatic sine_rom_type build_sine();
      sine_rom_type     rom;
      int unsigned      quad;
      int unsigned      r;
      logic signed [15:0] m;
      begin
         for (int unsigned i = 0; i < ROM_SIZE; i++) begin
            quad = i / QUARTER;
            r    = i % QUARTER;
            m    = quad[0] ? quarter_sine(QUARTER - r) : quarter_sine(r);
            rom[i] = quad[1] ? -m : m;
         end
         return rom;
      end
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine();

endpackage

FILE: src/dtb_front.sv
// Front end: control registers, burst state, phase accumulator and envelope.
// Classifies each transaction and hands sample commands to the queue; uses dtb_pkg.
module dtb_front import dtb_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   input  logic                      req_start_req,
   input  logic [1:0]                req_voice,
   input  logic [31:0]               req_phase_step,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [REG_W-1:0]          csr_wdata,
   input  cq_status_type             q_status,
   output logic                      req_full,
   output logic                      cmd_push,
   output cmd_type                   cmd
);

   logic [REG_W-1:0] attack_step_ff, attack_step_in;
   logic [REG_W-1:0] decay_step_ff, decay_step_in;
   logic [REG_W-1:0] attack_ticks_ff, attack_ticks_in;
   logic [REG_W-1:0] decay_ticks_ff, decay_ticks_in;
   logic [REG_W-1:0] burst_length_ff, burst_length_in;

   logic [31:0]           phase_ff, phase_in;
   logic [31:0]           held_ff, held_in;
   logic [15:0]           amp_ff, amp_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  active_ff, active_in;

   logic                  accept;
   logic                  voiced;
   logic [31:0]           step_use;
   logic [16:0]           amp_up;
   logic [CMP_W-1:0]      decay_sum;
   logic [COUNT_BITS-1:0] count_inc;
   logic                  done;

   assign req_full = q_status.full;
   assign accept   = req_push && !q_status.full;
   assign voiced   = (req_voice == VOICE_SWOOP) || (req_voice == VOICE_CHIRP);
   assign step_use = voiced ? req_phase_step : held_ff;
   assign amp_up   = {1'b0, amp_ff} + {1'b0, attack_step_ff};
   assign decay_sum = CMP_W'(count_ff) + CMP_W'(decay_ticks_ff);
   assign count_inc = count_ff + 1'b1;
   assign done      = (CMP_W'(count_inc) == CMP_W'(burst_length_ff));
   assign cmd_push  = accept && (active_ff || req_start_req);

   always_comb begin
      attack_step_in  = attack_step_ff;
      decay_step_in   = decay_step_ff;
      attack_ticks_in = attack_ticks_ff;
      decay_ticks_in  = decay_ticks_ff;
      burst_length_in = burst_length_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            REG_ATTACK_STEP:  attack_step_in  = csr_wdata;
            REG_DECAY_STEP:   decay_step_in   = csr_wdata;
            REG_ATTACK_TICKS: attack_ticks_in = csr_wdata;
            REG_DECAY_TICKS:  decay_ticks_in  = csr_wdata;
            REG_BURST_LENGTH: burst_length_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      held_in   = held_ff;
      amp_in    = amp_ff;
      count_in  = count_ff;
      active_in = active_ff;
      if (cmd_push) begin
         active_in = 1'b1;
         held_in   = step_use;
         phase_in  = phase_ff + step_use;
         priority if (CMP_W'(count_ff) < CMP_W'(attack_ticks_ff)) begin
            amp_in = amp_up[16] ? 16'hffff : amp_up[15:0];
         end else if (decay_sum > CMP_W'(burst_length_ff)) begin
            amp_in = (amp_ff > decay_step_ff) ? amp_ff - decay_step_ff : '0;
         end else begin
            amp_in = amp_ff;
         end
         count_in = count_inc;
         if (done) begin
            count_in  = '0;
            amp_in    = '0;
            active_in = 1'b0;
         end
      end
   end

   // the multiply uses the amplitude from before this tick's envelope update
   always_comb begin
      cmd.addr       = phase_in[31 -: SINE_ADDR_BITS];
      cmd.amp        = amp_ff;
      cmd.voiced     = voiced;
      cmd.next_index = 16'(count_in);
      cmd.done       = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_step_ff  <= RST_ATTACK_STEP;
         decay_step_ff   <= RST_DECAY_STEP;
         attack_ticks_ff <= RST_ATTACK_TICKS;
         decay_ticks_ff  <= RST_DECAY_TICKS;
         burst_length_ff <= RST_BURST_LENGTH;
         phase_ff        <= '0;
         held_ff         <= '0;
         amp_ff          <= '0;
         count_ff        <= '0;
         active_ff       <= 1'b0;
      end else begin
         attack_step_ff  <= attack_step_in;
         decay_step_ff   <= decay_step_in;
         attack_ticks_ff <= attack_ticks_in;
         decay_ticks_ff  <= decay_ticks_in;
         burst_length_ff <= burst_length_in;
         phase_ff        <= phase_in;
         held_ff         <= held_in;
         amp_ff          <= amp_in;
         count_ff        <= count_in;
         active_ff       <= active_in;
      end
   end

endmodule

FILE: src/dtb_cmd_queue.sv
// Short command queue between the front end and the sample back end.
// Holds CQ_DEPTH commands in registers; uses dtb_pkg.
module dtb_cmd_queue import dtb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  cmd_type       push_cmd,
   input  logic          pop,
   output cmd_type       head,
   output cq_status_type status
);

   cmd_type                entry_ff [CQ_DEPTH];
   logic [CQ_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CQ_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CQ_CNT_BITS-1:0] count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign status.full  = (count_ff == CQ_CNT_BITS'(CQ_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == CQ_PTR_BITS'(CQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == CQ_PTR_BITS'(CQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: src/dtb_back.sv
// Back end: sine lookup, amplitude scaling, DAC code mapping and result register.
// Takes commands from dtb_cmd_queue; uses dtb_pkg.
module dtb_back import dtb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cq_status_type q_status,
   input  cmd_type       head,
   output logic          q_pop,
   input  logic          rsp_pop,
   output logic          rsp_empty,
   output logic [15:0]   rsp_dac_word,
   output logic [15:0]   rsp_next_index,
   output logic          rsp_burst_done
);

   typedef enum logic [1:0] {
      B_IDLE,
      B_MUL,
      B_SCALE
   } state_type;

   state_type                 state_ff, state_in;
   logic signed [15:0]        sine_ff, sine_in;
   logic [15:0]               amp_ff, amp_in;
   logic                      voiced_ff, voiced_in;
   logic [15:0]               index_ff, index_in;
   logic                      done_ff, done_in;
   logic signed [17:0]        s_ff, s_in;
   logic                      valid_ff, valid_in;
   logic [15:0]               dac_ff, dac_in;
   logic [15:0]               rsp_index_ff, rsp_index_in;
   logic                      rsp_done_ff, rsp_done_in;

   logic signed [32:0]        prod1;
   logic signed [29:0]        prod2;
   logic signed [15:0]        code_wide;
   logic [11:0]               code;
   logic                      slot_free;

   assign prod1     = $signed({1'b0, amp_ff}) * sine_ff;
   assign prod2     = s_ff * DAC_SCALE;
   assign code_wide = $signed({prod2[29], prod2[29:15]}) + DAC_OFFSET;
   assign slot_free = !valid_ff || rsp_pop;

   always_comb begin
      priority if (code_wide < 16'sd0) code = '0;
      else if (code_wide > DAC_MAX)     code = 12'hfff;
      else                              code = code_wide[11:0];
   end

   always_comb begin
      state_in     = state_ff;
      sine_in      = sine_ff;
      amp_in       = amp_ff;
      voiced_in    = voiced_ff;
      index_in     = index_ff;
      done_in      = done_ff;
      s_in         = s_ff;
      valid_in     = valid_ff && !rsp_pop;
      dac_in       = dac_ff;
      rsp_index_in = rsp_index_ff;
      rsp_done_in  = rsp_done_ff;
      q_pop        = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_status.empty) begin
               q_pop     = 1'b1;
               sine_in   = SINE_ROM[head.addr];
               amp_in    = head.amp;
               voiced_in = head.voiced;
               index_in  = head.next_index;
               done_in   = head.done;
               state_in  = B_MUL;
            end
         end
         B_MUL: begin
            // floor of amplitude times sine over 2^15; silence unvoiced ticks
            s_in     = voiced_ff ? prod1[32:15] : '0;
            state_in = B_SCALE;
         end
         B_SCALE: begin
            // hold here until the result register is free
            if (slot_free) begin
               valid_in     = 1'b1;
               dac_in       = CHAN_A_BITS | {4'b0000, code};
               rsp_index_in = index_ff;
               rsp_done_in  = done_ff;
               state_in     = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      sine_ff      <= sine_in;
      amp_ff       <= amp_in;
      voiced_ff    <= voiced_in;
      index_ff     <= index_in;
      done_ff      <= done_in;
      s_ff         <= s_in;
      dac_ff       <= dac_in;
      rsp_index_ff <= rsp_index_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign rsp_empty      = !valid_ff;
   assign rsp_dac_word   = dac_ff;
   assign rsp_next_index = rsp_index_ff;
   assign rsp_burst_done = rsp_done_ff;

endmodule

FILE: src/dds_tone_burst_with_envelope.sv
// Top level of the tone burst synthesiser with attack/decay envelope.
// Instantiates dtb_front, dtb_cmd_queue and dtb_back; uses dtb_pkg and assert_macros.svh.
//
// Usage: each transaction on the req_ queue is one audio sample tick carrying
// start_req, voice and the phase step for the tick index last reported in
// rsp_next_index. An idle tick (no burst, no start) is taken and gives no
// result. Every burst tick gives one result on the rsp_ queue: the channel-A
// DAC word, the next tick index and a flag on the last sample of the burst.
// Ticks enter the two-entry command queue at one per cycle while it is not full; the
// back end runs each command through lookup, scale and DAC-mapping steps with two
// dependent multipliers and takes the next command only after registering its result.
// The five csr_ registers are written by index with no wait; the user must write them
// only while idle, as the block itself does not enforce this rule.
// Reset (synchronous) restores register defaults and clears phase, envelope,
// tick count and both queues. When rsp_pop stays low the finished result is
// held, the back end waits, and req_full rises once the command queue fills.
`include "assert_macros.svh"

module dds_tone_burst_with_envelope import dtb_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic                      req_start_req,
   input  logic [1:0]                req_voice,
   input  logic [31:0]               req_phase_step,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [15:0]               rsp_dac_word,
   output logic [15:0]               rsp_next_index,
   output logic                      rsp_burst_done,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [REG_W-1:0]          csr_wdata
);

   cq_status_type q_status;
   cmd_type       push_cmd;
   cmd_type       head;
   logic          cmd_push;
   logic          q_pop;

   dtb_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_start_req  (req_start_req),
      .req_voice      (req_voice),
      .req_phase_step (req_phase_step),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .q_status       (q_status),
      .req_full       (req_full),
      .cmd_push       (cmd_push),
      .cmd            (push_cmd)
   );

   dtb_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head     (head),
      .status   (q_status)
   );

   dtb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .head           (head),
      .q_pop          (q_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_dac_word   (rsp_dac_word),
      .rsp_next_index (rsp_next_index),
      .rsp_burst_done (rsp_burst_done)
   );

   `ASSERT_ALWAYS(a_queue_status, clock, reset, !(q_status.full && q_status.empty))
   `ASSERT_IMPLIES(a_queue_fill, clock, reset, cmd_push && q_status.empty, ##1 !q_status.empty)
   `ASSERT_IMPLIES(a_done_index, clock, reset, !rsp_empty && rsp_burst_done, (rsp_next_index == '0))
   `ASSERT_IMPLIES(a_chan_bits, clock, reset, !rsp_empty, (rsp_dac_word[15:12] == CHAN_A_BITS[15:12]))

endmodule
